// ----- rtl/rhd_pkg.sv -----
// ============================================================================
// rhd_pkg
// Shared constants and the front-to-back command type of the RTP H.264
// depacketizer.
// ============================================================================
package rhd_pkg;

    // Parameter defaults
    localparam int SLOTS_DEFAULT      = 8;
    localparam int SLOT_BYTES_DEFAULT = 524288;

    // RTP framing
    localparam int         HEADER_BYTES = 12;
    localparam logic [6:0] PT_RESET     = 7'd105;

    // NAL codes
    localparam logic [7:0] NAL_SPS   = 8'h67;
    localparam logic [7:0] NAL_PPS   = 8'h68;
    localparam logic [4:0] FU_A_TYPE = 5'd28;

    // At most one command per accepted input item. start_code implies write_en.
    typedef struct packed {
        logic       rearm;
        logic       start_code;
        logic       write_en;
        logic       close_frame;
        logic [7:0] data;
    } t_cmd;

endpackage

// ----- rtl/rhd_front.sv -----
// ============================================================================
// rhd_front
// Packet parser: skips the RTP header, filters on payload type, classifies
// the payload and turns each byte into one command for the writer.
// ============================================================================
module rhd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic [6:0]        i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_packet_end,
    input  logic              i_rearm,
    input  logic              i_q_full,
    output logic              o_push,
    output rhd_pkg::t_cmd     o_cmd
);

    localparam logic [2:0] MODE_HEADER = 3'd0;
    localparam logic [2:0] MODE_FIRST  = 3'd1;
    localparam logic [2:0] MODE_BODY   = 3'd2;
    localparam logic [2:0] MODE_FUHDR  = 3'd3;
    localparam logic [2:0] MODE_FUBODY = 3'd4;
    localparam logic [2:0] MODE_DROP   = 3'd5;

    logic [6:0] r_payload_type;
    logic [3:0] r_pos,  n_pos;
    logic [2:0] r_mode, n_mode;
    logic [2:0] r_nri,  n_nri;
    logic       r_end,  n_end;

    logic          accept;
    logic          done;
    logic          param_set;
    rhd_pkg::t_cmd cmd;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign param_set  = (i_in_byte == rhd_pkg::NAL_SPS) || (i_in_byte == rhd_pkg::NAL_PPS);

    always_comb begin
        n_pos  = r_pos;
        n_mode = r_mode;
        n_nri  = r_nri;
        n_end  = r_end;
        done   = 1'b0;
        cmd             = '0;
        cmd.rearm       = i_rearm;
        cmd.data        = i_in_byte;
        unique case (r_mode)
            MODE_HEADER: begin
                if (r_pos == 4'd1 && i_in_byte[6:0] != r_payload_type) begin
                    n_mode = MODE_DROP;
                end else if (r_pos >= 4'(rhd_pkg::HEADER_BYTES - 1)) begin
                    n_mode = MODE_FIRST;
                end
                if (r_pos != 4'd15) begin
                    n_pos = r_pos + 4'd1;
                end
            end
            MODE_FIRST: begin
                if (param_set || i_in_byte[4:0] != rhd_pkg::FU_A_TYPE) begin
                    n_end          = !param_set;
                    cmd.start_code = 1'b1;
                    cmd.write_en   = 1'b1;
                    n_mode         = MODE_BODY;
                    done           = 1'b1;
                end else begin
                    n_nri  = i_in_byte[7:5];
                    n_end  = 1'b0;
                    n_mode = MODE_FUHDR;
                end
            end
            MODE_FUHDR: begin
                n_end          = i_in_byte[6];
                cmd.start_code = i_in_byte[7];
                cmd.write_en   = i_in_byte[7];
                cmd.data       = {r_nri, i_in_byte[4:0]};
                n_mode         = MODE_FUBODY;
                done           = 1'b1;
            end
            MODE_BODY, MODE_FUBODY: begin
                cmd.write_en = 1'b1;
                done         = 1'b1;
            end
            default: begin
            end
        endcase
        if (i_packet_end) begin
            cmd.close_frame = done && n_end;
            n_pos  = '0;
            n_mode = MODE_HEADER;
            n_end  = 1'b0;
        end
    end

    // Commands with nothing to do and no rearm are not queued.
    assign o_push = accept && (cmd.rearm || cmd.write_en || cmd.close_frame);
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_payload_type <= rhd_pkg::PT_RESET;
            r_pos          <= '0;
            r_mode         <= MODE_HEADER;
            r_nri          <= '0;
            r_end          <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_payload_type <= i_cfg_wr_data;
            end
            if (accept) begin
                r_pos  <= n_pos;
                r_mode <= n_mode;
                r_nri  <= n_nri;
                r_end  <= n_end;
            end
        end
    end

endmodule

// ----- rtl/rhd_cmd_queue.sv -----
// ============================================================================
// rhd_cmd_queue
// Small command FIFO between parser and writer.
// ============================================================================
module rhd_cmd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rhd_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output rhd_pkg::t_cmd o_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    rhd_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/rhd_back.sv -----
// ============================================================================
// rhd_back
// Frame writer: expands commands into byte and close results, tracks the
// frame length, slot, sync and overflow, and holds the output register.
// ============================================================================
module rhd_back #(
    parameter int SLOTS      = rhd_pkg::SLOTS_DEFAULT,
    parameter int SLOT_BYTES = rhd_pkg::SLOT_BYTES_DEFAULT,
    localparam int SLOT_W    = $clog2(SLOTS),
    localparam int OFF_W     = $clog2(SLOT_BYTES),
    localparam int LEN_W     = $clog2(SLOT_BYTES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  rhd_pkg::t_cmd     i_cmd,
    output logic              o_pop,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kind,
    output logic [7:0]        o_out_byte,
    output logic [SLOT_W-1:0] o_slot,
    output logic [OFF_W-1:0]  o_offset,
    output logic [LEN_W-1:0]  o_frame_size,
    output logic [SLOT_W-1:0] o_decode_slot,
    output logic              o_sync_found,
    output logic              o_overflow,
    output logic              o_run_last
);

    // Sub-steps of one command: four start-code bytes, the data byte, the close
    localparam logic [2:0] STEP_SC0   = 3'd0;
    localparam logic [2:0] STEP_SC3   = 3'd3;
    localparam logic [2:0] STEP_BYTE  = 3'd4;
    localparam logic [2:0] STEP_CLOSE = 3'd5;

    logic              r_busy, n_busy;
    logic [2:0]        r_step, n_step;
    logic [LEN_W-1:0]  r_len,  n_len;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_dec,  n_dec;
    logic              r_sync, n_sync;
    logic              r_ovf,  n_ovf;
    logic              r_head_ok, n_head_ok;

    logic              can_emit;
    logic              emit;
    logic              pop;
    logic [2:0]        cur_step;
    logic              sync_cur;
    logic              full;
    logic              at_cap;
    logic [7:0]        wr_byte;
    logic [7:0]        head_exp;
    logic              is_last;

    assign can_emit = !o_out_valid || !i_out_stall;
    assign cur_step = r_busy ? r_step
                    : (i_cmd.start_code ? STEP_SC0
                    : (i_cmd.write_en ? STEP_BYTE : STEP_CLOSE));
    assign sync_cur = (!r_busy && i_cmd.rearm) ? 1'b0 : r_sync;
    assign full     = (r_len >= LEN_W'(SLOT_BYTES));
    assign at_cap   = (r_len == LEN_W'(SLOT_BYTES - 1));

    always_comb begin
        unique case (cur_step)
            STEP_SC3:  wr_byte = 8'h01;
            STEP_BYTE: wr_byte = i_cmd.data;
            default:   wr_byte = 8'h00;
        endcase
        // Frame must open with 00 00 00 01 67 to count as a key frame
        unique case (r_len[2:0])
            3'd3:    head_exp = 8'h01;
            3'd4:    head_exp = rhd_pkg::NAL_SPS;
            default: head_exp = 8'h00;
        endcase
    end

    always_comb begin
        n_busy    = r_busy;
        n_step    = r_step;
        n_len     = r_len;
        n_slot    = r_slot;
        n_dec     = r_dec;
        n_sync    = r_sync;
        n_ovf     = r_ovf;
        n_head_ok = r_head_ok;
        emit      = 1'b0;
        pop       = 1'b0;
        is_last   = 1'b0;
        if (i_q_valid && can_emit) begin
            n_sync = sync_cur;
            if (!i_cmd.write_en && !i_cmd.close_frame) begin
                pop = 1'b1;
            end else if (cur_step == STEP_CLOSE) begin
                emit    = 1'b1;
                is_last = 1'b1;
                pop     = 1'b1;
                if (!sync_cur && r_len >= LEN_W'(5) && r_head_ok) begin
                    n_sync = 1'b1;
                    n_dec  = r_slot;
                end
            end else if (full) begin
                n_ovf = 1'b1;
                if (i_cmd.close_frame) begin
                    n_busy = 1'b1;
                    n_step = STEP_CLOSE;
                end else begin
                    pop = 1'b1;
                end
            end else begin
                emit  = 1'b1;
                n_len = r_len + 1'b1;
                if (r_len < LEN_W'(5) && wr_byte != head_exp) begin
                    n_head_ok = 1'b0;
                end
                is_last = !i_cmd.close_frame && (cur_step == STEP_BYTE || at_cap);
                if (cur_step != STEP_BYTE && !at_cap) begin
                    n_busy = 1'b1;
                    n_step = cur_step + 3'd1;
                end else begin
                    // remaining writes of this command would be dropped
                    if (cur_step != STEP_BYTE) begin
                        n_ovf = 1'b1;
                    end
                    if (i_cmd.close_frame) begin
                        n_busy = 1'b1;
                        n_step = STEP_CLOSE;
                    end else begin
                        pop = 1'b1;
                    end
                end
            end
            if (pop) begin
                n_busy = 1'b0;
            end
            if (emit && cur_step == STEP_CLOSE) begin
                n_len     = '0;
                n_head_ok = 1'b1;
                n_ovf     = 1'b0;
                n_slot    = (r_slot == SLOT_W'(SLOTS - 1)) ? '0 : r_slot + 1'b1;
            end
        end
    end

    assign o_pop = pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= STEP_SC0;
            r_len       <= '0;
            r_slot      <= '0;
            r_dec       <= '0;
            r_sync      <= 1'b0;
            r_ovf       <= 1'b0;
            r_head_ok   <= 1'b1;
            o_out_valid <= 1'b0;
        end else begin
            r_busy    <= n_busy;
            r_step    <= n_step;
            r_len     <= n_len;
            r_slot    <= n_slot;
            r_dec     <= n_dec;
            r_sync    <= n_sync;
            r_ovf     <= n_ovf;
            r_head_ok <= n_head_ok;
            if (can_emit) begin
                o_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            o_kind        <= (cur_step == STEP_CLOSE);
            o_out_byte    <= (cur_step == STEP_CLOSE) ? 8'h00 : wr_byte;
            o_slot        <= r_slot;
            o_offset      <= (cur_step == STEP_CLOSE) ? '0 : r_len[OFF_W-1:0];
            o_frame_size  <= (cur_step == STEP_CLOSE) ? r_len : '0;
            o_decode_slot <= n_dec;
            o_sync_found  <= n_sync;
            o_overflow    <= r_ovf;
            o_run_last    <= is_last;
        end
    end

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(SLOT_BYTES))
        else $error("frame length beyond slot capacity");

    a_busy_has_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> i_q_valid)
        else $error("writer mid-command with empty queue");

    a_sync_on_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sync) |-> $past(emit && cur_step == STEP_CLOSE))
        else $error("sync set outside a frame close");

endmodule

// ----- rtl/rtp_h264_depacketizer.sv -----
// ============================================================================
// rtp_h264_depacketizer
// RTP H.264 depacketizer: reassembles single NAL and FU-A packets into
// frame slots, reporting every stored byte and every frame close.
// ============================================================================
// Path: an accepted input byte is registered in the command queue, and its
//   results in the writer output register; the parser is combinational.
// Throughput: one input byte per cycle for plain payload bytes while the
//   queue is not full; a byte that opens a NAL unit produces five results
//   (start code plus header), six with a close, and the single writer emits
//   one result per cycle while the output is not stalled.
// Reset: synchronous active-low; clears parser, queue, frame and sync state;
//   payload_type returns to 105. No clearing pass is needed.
// ----------------------------------------------------------------------------
// Structure:
//   rhd_front      parses the RTP header, filters on payload type and turns
//                  each byte into a command (start code, write, close, rearm).
//   rhd_cmd_queue  four-entry command FIFO; its full flag is the input stall.
//   rhd_back       expands commands one result per cycle unless the output
//                  stalls, tracks frame length, slot rotation, key-frame sync
//                  and overflow, and owns the output register.
// ============================================================================
module rtp_h264_depacketizer #(
    parameter int SLOTS      = rhd_pkg::SLOTS_DEFAULT,
    parameter int SLOT_BYTES = rhd_pkg::SLOT_BYTES_DEFAULT,
    localparam int SLOT_W    = $clog2(SLOTS),
    localparam int OFF_W     = $clog2(SLOT_BYTES),
    localparam int LEN_W     = $clog2(SLOT_BYTES + 1)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: payload_type
    input  logic              i_cfg_wr_en,
    input  logic [6:0]        i_cfg_wr_data,
    // input item channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_packet_end,
    input  logic              i_rearm,
    // result item channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_kind,
    output logic [7:0]        o_out_byte,
    output logic [SLOT_W-1:0] o_slot,
    output logic [OFF_W-1:0]  o_offset,
    output logic [LEN_W-1:0]  o_frame_size,
    output logic [SLOT_W-1:0] o_decode_slot,
    output logic              o_sync_found,
    output logic              o_overflow,
    output logic              o_run_last
);

    localparam int QUEUE_DEPTH = 4;

    logic          q_push;
    logic          q_full;
    logic          q_valid;
    logic          q_pop;
    rhd_pkg::t_cmd front_cmd;
    rhd_pkg::t_cmd head_cmd;

    // Parser: classifies each byte; stalls only when the queue is full
    rhd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_byte     (i_in_byte),
        .i_packet_end  (i_packet_end),
        .i_rearm       (i_rearm),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    // Decouples the bursty start-code expansion from the byte stream
    rhd_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    // Writer: one result per cycle into the output register unless the output stalls
    rhd_back #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_cmd         (head_cmd),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_slot        (o_slot),
        .o_offset      (o_offset),
        .o_frame_size  (o_frame_size),
        .o_decode_slot (o_decode_slot),
        .o_sync_found  (o_sync_found),
        .o_overflow    (o_overflow),
        .o_run_last    (o_run_last)
    );

endmodule
